// ----- rtl/wsmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Word stream message deframer package
// Shared constants and the queue entry type passed from front to back.
// ----------------------------------------------------------------------------
package wsmd_pkg;

  localparam int unsigned WordWidth    = 32;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned LenWidth     = 8;
  localparam int unsigned BytesPerWord = 4;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [15:0] StartMark = 16'hFFFF;

  // One queue entry describes the bytes that one accepted item yields.
  typedef struct packed {
    logic [WordWidth-1:0] data;
    logic [1:0]           cnt_m1;
    logic                 last;
    logic                 bad;
  } entry_t;

endpackage

// ----- rtl/wsmd_front.sv -----
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts words, tracks the message state and classifies each word into a
// queue entry holding its byte data, byte count and end and error marks.
// ----------------------------------------------------------------------------
module wsmd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  output logic                               in_stall,
  input  logic [wsmd_pkg::WordWidth-1:0]     in_word,
  output logic                               push,
  output wsmd_pkg::entry_t                   push_entry,
  input  logic                               q_full
);

  logic [wsmd_pkg::LenWidth-1:0] bytes_left_r;
  logic [wsmd_pkg::LenWidth-1:0] bytes_left_nxt;
  logic                          accept;

  assign in_stall = q_full;
  assign accept   = in_vld && !q_full;
  assign push     = accept;

  always_comb begin
    push_entry     = '0;
    bytes_left_nxt = bytes_left_r;
    if (bytes_left_r == '0) begin
      if (in_word[31:16] == wsmd_pkg::StartMark) begin
        push_entry.data = {24'b0, in_word[15:8]};
        push_entry.last = (in_word[7:0] == 8'd0);
        bytes_left_nxt  = in_word[7:0];
      end else begin
        push_entry.bad = 1'b1;
      end
    end else begin
      push_entry.data = in_word;
      if (bytes_left_r > 8'(wsmd_pkg::BytesPerWord)) begin
        push_entry.cnt_m1 = 2'd3;
        bytes_left_nxt    = bytes_left_r - 8'(wsmd_pkg::BytesPerWord);
      end else begin
        push_entry.cnt_m1 = 2'(bytes_left_r - 8'd1);
        push_entry.last   = 1'b1;
        bytes_left_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
    end else if (accept) begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

// ----- rtl/wsmd_fifo.sv -----
// ----------------------------------------------------------------------------
// Deframer entry queue
// A short first-in first-out queue of entries between front and back ends.
// ----------------------------------------------------------------------------
module wsmd_fifo #(
  parameter int unsigned DEPTH = wsmd_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wsmd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output wsmd_pkg::entry_t q_entry
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wsmd_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/wsmd_back.sv -----
// ----------------------------------------------------------------------------
// Deframer back end
// Takes queue entries and sends their bytes one per cycle, unless the output
// stalls, via an output register, marking each message's end and bad headers.
// ----------------------------------------------------------------------------
module wsmd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  wsmd_pkg::entry_t                   q_entry,
  output logic                               pop,
  output logic                               out_vld,
  input  logic                               out_stall,
  output logic [wsmd_pkg::ByteWidth-1:0]     out_byte,
  output logic                               out_last,
  output logic                               out_bad_header
);

  logic                              cur_valid_r;
  logic [wsmd_pkg::WordWidth-1:0]    cur_data_r;
  logic [1:0]                        cur_left_r;
  logic                              cur_last_r;
  logic                              cur_bad_r;
  logic                              out_vld_r;
  logic [wsmd_pkg::ByteWidth-1:0]    out_byte_r;
  logic                              out_last_r;
  logic                              out_bad_r;
  logic                              load_ok;
  logic                              emit;
  logic                              fin;

  assign load_ok = !out_vld_r || !out_stall;
  assign emit    = load_ok && cur_valid_r;
  assign fin     = emit && (cur_left_r == 2'd0);
  assign pop     = q_valid && (!cur_valid_r || fin);

  assign out_vld        = out_vld_r;
  assign out_byte       = out_byte_r;
  assign out_last       = out_last_r;
  assign out_bad_header = out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
      end else if (fin) begin
        cur_valid_r <= 1'b0;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_data_r <= q_entry.data;
      cur_left_r <= q_entry.cnt_m1;
      cur_last_r <= q_entry.last;
      cur_bad_r  <= q_entry.bad;
    end else if (emit) begin
      cur_data_r <= cur_data_r >> wsmd_pkg::ByteWidth;
      cur_left_r <= cur_left_r - 2'd1;
    end
    if (emit) begin
      out_byte_r <= cur_data_r[wsmd_pkg::ByteWidth-1:0];
      out_last_r <= cur_last_r && (cur_left_r == 2'd0);
      out_bad_r  <= cur_bad_r;
    end
  end

endmodule

// ----- rtl/word_stream_message_deframer.sv -----
// ----------------------------------------------------------------------------
// Word stream message deframer
// Turns 32-bit header and payload words into a byte stream of messages.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in_       input      in_vld / in_stall     in_word [31:0]
// out_      output     out_vld / out_stall   out_byte [7:0], out_last, out_bad_header
//
// Each item yields one to four bytes, one per cycle through the output
// register while the output is not stalled. A header or a bad header yields
// one byte; a full payload word yields four.
// The front end runs ahead of the back end by up to QDEPTH queued items.
// Reset clears the message state, the queue and the output register.
// A stall on the output holds the byte shown and fills the queue behind it.
// ----------------------------------------------------------------------------
module word_stream_message_deframer #(
  parameter int unsigned QDEPTH = wsmd_pkg::QueueDepth
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  output logic                               in_stall,
  input  logic [wsmd_pkg::WordWidth-1:0]     in_word,
  output logic                               out_vld,
  input  logic                               out_stall,
  output logic [wsmd_pkg::ByteWidth-1:0]     out_byte,
  output logic                               out_last,
  output logic                               out_bad_header
);

  logic             push;
  logic             q_full;
  logic             pop;
  logic             q_valid;
  wsmd_pkg::entry_t push_entry;
  wsmd_pkg::entry_t q_entry;

  wsmd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_vld),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  wsmd_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  wsmd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .pop            (pop),
    .out_vld        (out_vld),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_bad_header (out_bad_header)
  );

endmodule

// ----- bench/word_stream_message_deframer_checker.sv -----
// ----------------------------------------------------------------------------
// Word stream message deframer checker
// Watches both channels of the deframer. Each accepted input item is run
// through a local model of the header and payload state, and the bytes that it
// should yield are queued. Each accepted output item is compared field by field
// with the oldest queued byte. The failure count and the number of bytes still
// owed are handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_stream_message_deframer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic                           in_stall,
  input  logic [wsmd_pkg::WordWidth-1:0] in_word,
  input  logic                           out_vld,
  input  logic                           out_stall,
  input  logic [wsmd_pkg::ByteWidth-1:0] out_byte,
  input  logic                           out_last,
  input  logic                           out_bad_header,
  output int                             fail_count,
  output int                             bytes_owed
);

  typedef struct {
    logic [wsmd_pkg::ByteWidth-1:0] msg_byte;
    logic                           last;
    logic                           bad_header;
  } deframed_byte_t;

  deframed_byte_t                owed_q[$];
  deframed_byte_t                want;
  logic                          msg_open;
  logic [wsmd_pkg::LenWidth-1:0] payload_left;

  task automatic owe_byte(input logic [wsmd_pkg::ByteWidth-1:0] b, input logic lst,
                          input logic bad);
    deframed_byte_t e;
    e.msg_byte   = b;
    e.last       = lst;
    e.bad_header = bad;
    owed_q.push_back(e);
  endtask

  // Works out the bytes that one accepted word yields and updates the message
  // state to match.
  task automatic deframe_word(input logic [wsmd_pkg::WordWidth-1:0] w);
    if (!msg_open || payload_left == 0) begin
      if (w[31:16] != wsmd_pkg::StartMark) begin
        owe_byte('0, 1'b0, 1'b1);
        msg_open     = 1'b0;
        payload_left = '0;
      end else begin
        owe_byte(w[15:8], w[7:0] == 0, 1'b0);
        payload_left = w[7:0];
        msg_open     = w[7:0] != 0;
      end
    end else begin
      for (int i = 0; i < wsmd_pkg::BytesPerWord; i++) begin
        if (payload_left != 0) begin
          payload_left = payload_left - 1'b1;
          owe_byte(w[8*i +: 8], payload_left == 0, 1'b0);
        end
      end
      if (payload_left == 0) msg_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_q.delete();
      msg_open     = 1'b0;
      payload_left = '0;
      fail_count   = 0;
    end else begin
      if (out_vld && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("unexpected output item: byte %h last %b bad_header %b",
                 out_byte, out_last, out_bad_header);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_byte !== want.msg_byte) begin
            $error("out_byte: expected %h, actual %h", want.msg_byte, out_byte);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, out_last);
            fail_count++;
          end
          if (out_bad_header !== want.bad_header) begin
            $error("out_bad_header: expected %b, actual %b", want.bad_header,
                   out_bad_header);
            fail_count++;
          end
        end
      end
      if (in_vld && !in_stall) deframe_word(in_word);
    end
    bytes_owed = owed_q.size();
  end

endmodule

// ----- bench/word_stream_message_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// Word stream message deframer testbench
// Drives headers, payload words and malformed words into the deframer with
// random gaps on the input and random stalls on the output, and leaves the
// checking to the checker instantiated beside the block. A short directed
// part covers bad headers, zero-length messages and dropped surplus bytes;
// the random part is mostly well-formed messages with some noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_stream_message_deframer_tb;

  localparam int WordTarget = 480;

  logic                           clk;
  logic                           rst_n;
  logic                           in_vld;
  logic                           in_stall;
  logic [wsmd_pkg::WordWidth-1:0] in_word;
  logic                           out_vld;
  logic                           out_stall;
  logic [wsmd_pkg::ByteWidth-1:0] out_byte;
  logic                           out_last;
  logic                           out_bad_header;
  int                             fail_count;
  int                             bytes_owed;
  int                             words_sent;
  logic                           calm;

  word_stream_message_deframer u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (in_vld),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_vld       (out_vld),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_bad_header(out_bad_header)
  );

  word_stream_message_deframer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (in_vld),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_vld       (out_vld),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_bad_header(out_bad_header),
    .fail_count    (fail_count),
    .bytes_owed    (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    int   run;
    logic hold;
    run       = 0;
    hold      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        hold = $urandom_range(0, 2) == 0;
        run  = hold ? idle_len() : $urandom_range(1, 12);
      end
      out_stall <= calm ? 1'b0 : hold;
      run--;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [wsmd_pkg::WordWidth-1:0] w);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_vld <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_vld  <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input logic [7:0] id, input logic [7:0] len);
    logic [wsmd_pkg::WordWidth-1:0] w;
    send_word({wsmd_pkg::StartMark, id, len});
    repeat ((int'(len) + 3) / 4) begin
      w = $urandom();
      if ($urandom_range(0, 7) == 0) w[31:16] = wsmd_pkg::StartMark;
      send_word(w);
    end
  endtask

  initial begin
    logic [wsmd_pkg::WordWidth-1:0] w;
    logic [7:0]                     len;
    int                             r;
    int                             msg_cnt;
    rst_n      = 1'b0;
    in_vld     = 1'b0;
    in_word    = '0;
    calm       = 1'b0;
    words_sent = 0;
    msg_cnt    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(32'h0000_0000);
    send_word(32'hFFFE_FFFF);
    send_word(32'h7FFF_1234);
    send_word(32'hFFFF_FF00);
    send_word(32'hFFFF_0000);
    send_message(8'hA5, 8'd1);
    send_message(8'h00, 8'd4);
    send_message(8'hFF, 8'd5);
    send_message(8'h3C, 8'd2);
    send_message(8'h81, 8'd3);
    send_word(32'hFFFF_1108);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);

    while (words_sent < WordTarget) begin
      if ($urandom_range(0, 39) == 0) calm <= ~calm;
      r = $urandom_range(0, 9);
      if (r < 8) begin
        r = $urandom_range(0, 19);
        if (msg_cnt == 5) len = 8'd255;
        else if (r < 14) len = $urandom_range(0, 12);
        else if (r < 19) len = $urandom_range(13, 40);
        else len = $urandom_range(200, 255);
        send_message($urandom_range(0, 255), len);
        msg_cnt++;
      end else begin
        w = $urandom();
        if (r == 8) w[31:16] = wsmd_pkg::StartMark ^ (16'h1 << $urandom_range(0, 15));
        else if (w[31:16] == wsmd_pkg::StartMark) w[31] = 1'b0;
        send_word(w);
      end
    end

    in_vld <= 1'b0;
    calm   <= 1'b1;
    while (bytes_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
